[design/secded_72_64_codec_core_macros.svh]
// Assertion helpers for the SECDED codec.
// Clock and reset names are those of the codec core.
`ifndef SECDED_72_64_CODEC_CORE_MACROS_SVH
`define SECDED_72_64_CODEC_CORE_MACROS_SVH

// Checked only outside reset
`define SECDED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define SECDED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/secded_pkg.sv]
`timescale 1ns / 1ps

package secded_pkg;

  // Error counter width; totals are reported on 32 bits
  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_WIDTH = 32;

  localparam int DATA_WIDTH = 64;
  localparam int CHECK_WIDTH = 8;
  localparam int HAM_WIDTH = 7;

  // Operation codes
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CORR    = 2'd1,
    STATUS_UNCORR  = 2'd2
  } status_e;

  typedef logic [HAM_WIDTH-1:0] pos_t;

  // Codeword position of each data bit: non-powers of two in 1..71
  localparam pos_t POS_OF_BIT [DATA_WIDTH] = '{
    7'd3,  7'd5,  7'd6,  7'd7,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15,
    7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27,
    7'd28, 7'd29, 7'd30, 7'd31,
    7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd43,
    7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54,
    7'd55, 7'd56, 7'd57, 7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63,
    7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71
  };

  // Data bits that feed Hamming check bit j
  function automatic logic [DATA_WIDTH-1:0] ham_mask(input logic [2:0] j);
    logic [DATA_WIDTH-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      m[i] = POS_OF_BIT[i][j];
    end
    return m;
  endfunction

endpackage

[design/secded_in_if.sv]
`timescale 1ns / 1ps

// Request channel: one word to encode or decode per beat
interface secded_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] data_word;
  logic [7:0]  check_in;

  modport source (output valid, output func, output data_word, output check_in,
                  input ready);
  modport sink   (input valid, input func, input data_word, input check_in,
                  output ready);
endinterface

[design/secded_out_if.sv]
`timescale 1ns / 1ps

// Response channel: one result per beat
interface secded_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;
  logic [7:0]  check_out;
  logic [1:0]  status;
  logic [31:0] corrected_total;
  logic [31:0] uncorrectable_total;

  modport source (output valid, output data_out, output check_out, output status,
                  output corrected_total, output uncorrectable_total,
                  input ready);
  modport sink   (input valid, input data_out, input check_out, input status,
                  input corrected_total, input uncorrectable_total,
                  output ready);
endinterface

[design/secded_72_64_codec_core.sv]
`timescale 1ns / 1ps
// Channel  Port   Dir  Payload
// request  req_i  in   func, data_word[63:0], check_in[7:0]
// response rsp_o  out  data_out[63:0], check_out[7:0], status[1:0],
//                      corrected_total[31:0], uncorrectable_total[31:0]
//
// One beat per cycle in each direction while results are taken; a request beat is captured in
// the input register and then moves into the result register, which drives response valid.
// Check generation, syndrome decode and correction sit between the two registers.
// Reset clears the stage valid flags and both error counters.
// A stalled response holds the result register; one more request fills the input
// register, after which ready stays low until the waiting result is taken.

`include "secded_72_64_codec_core_macros.svh"

module secded_72_64_codec_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  secded_in_if.sink    req_i,
  secded_out_if.source rsp_o
);

  localparam int CW = secded_pkg::COUNT_WIDTH;
  localparam int TW = secded_pkg::TOTAL_WIDTH;
  localparam int DW = secded_pkg::DATA_WIDTH;
  localparam int HW = secded_pkg::HAM_WIDTH;

  // Input register
  logic                                 in_vld_q;
  logic                                 func_q;
  logic [DW-1:0]                        data_q;
  logic [secded_pkg::CHECK_WIDTH-1:0]   chk_in_q;

  // Result register
  logic                                 out_vld_q;
  logic [DW-1:0]                        data_out_q;
  logic [secded_pkg::CHECK_WIDTH-1:0]   chk_out_q;
  secded_pkg::status_e                  status_q;

  // Error counters
  logic [CW-1:0] corr_q, corr_d;
  logic [CW-1:0] uncorr_q, uncorr_d;

  logic in_vld_d, out_vld_d;
  logic res_free, advance, req_fire;

  // Handshake
  assign res_free  = !out_vld_q || rsp_o.ready;
  assign advance   = in_vld_q && res_free;
  assign req_i.ready = !in_vld_q || res_free;
  assign req_fire  = req_i.valid && req_i.ready;

  assign in_vld_d  = req_fire ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d = advance ? 1'b1 : (rsp_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      corr_q    <= '0;
      uncorr_q  <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      corr_q    <= corr_d;
      uncorr_q  <= uncorr_d;
    end
  end

  // Input payload capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q   <= req_i.func;
      data_q   <= req_i.data_word;
      chk_in_q <= req_i.check_in;
    end
  end

  // Check byte from the word as it arrived
  logic [HW-1:0]                      ham;
  logic                               par_w;
  logic [secded_pkg::CHECK_WIDTH-1:0] chk_calc;

  always_comb begin
    for (int j = 0; j < HW; j++) begin
      ham[j] = ^(data_q & secded_pkg::ham_mask(3'(j)));
    end
  end

  assign par_w    = ^data_q;
  assign chk_calc = {par_w ^ (^ham), ham};

  // Syndrome and overall parity
  logic [HW-1:0] syn;
  logic          ovr;
  logic [DW-1:0] flip;

  assign syn = ham ^ chk_in_q[HW-1:0];
  assign ovr = par_w ^ (^chk_in_q);

  // Single data bit that the syndrome points at, if any
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      flip[i] = (syn == secded_pkg::POS_OF_BIT[i]);
    end
  end

  // Decode decision
  secded_pkg::status_e status_d;
  logic [DW-1:0]       data_d;

  always_comb begin
    status_d = secded_pkg::STATUS_OK;
    data_d   = data_q;
    if (func_q == secded_pkg::FUNC_DECODE) begin
      if (ovr) begin
        status_d = secded_pkg::STATUS_CORR;
        data_d   = data_q ^ flip;
      end else if (syn != '0) begin
        status_d = secded_pkg::STATUS_UNCORR;
      end
    end
  end

  // Saturating error counters, bumped as the item enters the result register
  always_comb begin
    corr_d   = corr_q;
    uncorr_d = uncorr_q;
    if (advance) begin
      if (status_d == secded_pkg::STATUS_CORR && corr_q != '1) begin
        corr_d = corr_q + 1'b1;
      end
      if (status_d == secded_pkg::STATUS_UNCORR && uncorr_q != '1) begin
        uncorr_d = uncorr_q + 1'b1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      data_out_q <= data_d;
      chk_out_q  <= chk_calc;
      status_q   <= status_d;
    end
  end

  // Totals on the reporting width
  logic [63:0] corr_ext, uncorr_ext;
  assign corr_ext   = 64'(corr_q);
  assign uncorr_ext = 64'(uncorr_q);

  assign rsp_o.valid               = out_vld_q;
  assign rsp_o.data_out            = data_out_q;
  assign rsp_o.check_out           = chk_out_q;
  assign rsp_o.status              = status_q;
  assign rsp_o.corrected_total     = corr_ext[TW-1:0];
  assign rsp_o.uncorrectable_total = uncorr_ext[TW-1:0];

  // Checks
  `SECDED_ASSERT_ALWAYS(a_cnt_reset, !rst_ni |-> (corr_q == '0 && uncorr_q == '0), "counters not cleared in reset")
  `SECDED_ASSERT(a_corr_bump, (advance && status_d == secded_pkg::STATUS_CORR && corr_q != '1) |=> (corr_q == $past(corr_q) + 1'b1), "corrected count missed an error")
  `SECDED_ASSERT(a_uncorr_hold, (!advance || status_d != secded_pkg::STATUS_UNCORR) |=> (uncorr_q == $past(uncorr_q)), "uncorrectable count moved without an error")
  `SECDED_ASSERT(a_data_kept, (in_vld_q && status_d != secded_pkg::STATUS_CORR) |-> (data_d == data_q), "data altered without a correction")
  `SECDED_ASSERT(a_encode_clean, (in_vld_q && func_q == secded_pkg::FUNC_ENCODE) |-> (status_d == secded_pkg::STATUS_OK), "encode reported an error")

endmodule

[bench/secded_72_64_codec_core_tb.sv]
`timescale 1ns / 1ps

module secded_72_64_codec_core_tb;

  // One response beat as the codec should produce it
  typedef struct packed {
    logic [63:0]         data;
    logic [7:0]          check;
    secded_pkg::status_e status;
    logic [31:0]         corr_total;
    logic [31:0]         uncorr_total;
  } codec_result_t;

  // Tracks the SECDED behaviour and the running error counts
  class codec_scoreboard;
    logic [6:0]    bit_pos [64];
    logic [63:0]   corr_cnt;
    logic [63:0]   uncorr_cnt;
    logic [63:0]   cnt_max;
    codec_result_t expected_q [$];
    int unsigned   mismatches;

    function new();
      int k = 0;
      // data bits sit on the codeword positions that are not powers of two
      for (int p = 1; p < 72; p++) begin
        if ((p & (p - 1)) != 0) begin
          bit_pos[k] = p[6:0];
          k++;
        end
      end
      cnt_max = (secded_pkg::COUNT_WIDTH >= 64) ? '1 :
                (64'd1 << secded_pkg::COUNT_WIDTH) - 64'd1;
      corr_cnt = '0;
      uncorr_cnt = '0;
      mismatches = 0;
    endfunction

    function logic [7:0] check_byte(logic [63:0] w);
      logic [6:0] h = '0;
      for (int i = 0; i < 64; i++) begin
        if (w[i]) h ^= bit_pos[i];
      end
      return {(^w) ^ (^h), h};
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic f, logic [63:0] w, logic [7:0] stored);
      codec_result_t exp_res;
      logic [6:0]    syn;
      logic          odd;
      exp_res.check = check_byte(w);
      exp_res.status = secded_pkg::STATUS_OK;
      if (f == secded_pkg::FUNC_DECODE) begin
        syn = exp_res.check[6:0] ^ stored[6:0];
        odd = (^w) ^ (^stored);
        if (odd) begin
          // single error: flip the data bit if the syndrome names one
          for (int i = 0; i < 64; i++) begin
            if (bit_pos[i] == syn) w[i] = ~w[i];
          end
          exp_res.status = secded_pkg::STATUS_CORR;
          if (corr_cnt < cnt_max) corr_cnt++;
        end else if (syn != '0) begin
          exp_res.status = secded_pkg::STATUS_UNCORR;
          if (uncorr_cnt < cnt_max) uncorr_cnt++;
        end
      end
      exp_res.data = w;
      exp_res.corr_total = corr_cnt[31:0];
      exp_res.uncorr_total = uncorr_cnt[31:0];
      expected_q.push_back(exp_res);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(codec_result_t got);
      codec_result_t exp_res;
      if (expected_q.size() == 0) begin
        report_mismatch("response beat with nothing outstanding");
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.data !== exp_res.data)
        report_mismatch($sformatf("data_out %h, want %h", got.data, exp_res.data));
      if (got.check !== exp_res.check)
        report_mismatch($sformatf("check_out %h, want %h", got.check, exp_res.check));
      if (got.status !== exp_res.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, exp_res.status));
      if (got.corr_total !== exp_res.corr_total)
        report_mismatch($sformatf("corrected_total %0d, want %0d",
                                  got.corr_total, exp_res.corr_total));
      if (got.uncorr_total !== exp_res.uncorr_total)
        report_mismatch($sformatf("uncorrectable_total %0d, want %0d",
                                  got.uncorr_total, exp_res.uncorr_total));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  secded_in_if  req_ch ();
  secded_out_if rsp_ch ();

  secded_72_64_codec_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  codec_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     rsp_stall_pct;
  int unsigned     rsp_hold_cycles;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case the codec hangs
  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Response side: random stalls, plus a long hold-off when asked
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Watch both channels for accepted beats
  always @(posedge clk_i) begin
    codec_result_t got;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.func, req_ch.data_word, req_ch.check_in);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.data = rsp_ch.data_out;
        got.check = rsp_ch.check_out;
        got.status = secded_pkg::status_e'(rsp_ch.status);
        got.corr_total = rsp_ch.corrected_total;
        got.uncorr_total = rsp_ch.uncorrectable_total;
        sb.check_result(got);
      end
    end
  end

  // Offer one request beat and hold it until taken; valid stays high afterwards
  task automatic send_beat(logic f, logic [63:0] w, logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      req_ch.func <= logic'($urandom_range(1));
      req_ch.data_word <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.data_word <= w;
    req_ch.check_in <= c;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Stop offering and wait for every outstanding response
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_decode(logic [63:0] w, logic [7:0] data_flip_lo, logic [7:0] chk_flip);
    logic [63:0] bad;
    bad = w;
    if (data_flip_lo != 8'hFF) bad[data_flip_lo[5:0]] = ~bad[data_flip_lo[5:0]];
    send_beat(secded_pkg::FUNC_DECODE, bad, sb.check_byte(w) ^ chk_flip);
  endtask

  // Mostly well-formed codewords with injected faults, some raw noise
  task automatic send_random_item();
    logic [63:0] w;
    logic [7:0]  c;
    int          kind;
    int          a;
    int          b;
    w = {$urandom, $urandom};
    c = sb.check_byte(w);
    kind = $urandom_range(99);
    a = $urandom_range(63);
    b = (a + 1 + $urandom_range(62)) % 64;
    if (kind < 25) begin
      send_beat(secded_pkg::FUNC_ENCODE, w, 8'($urandom_range(255)));
    end else if (kind < 40) begin
      send_beat(secded_pkg::FUNC_DECODE, w, c);
    end else if (kind < 60) begin
      w[a] = ~w[a];
      send_beat(secded_pkg::FUNC_DECODE, w, c);
    end else if (kind < 70) begin
      c[$urandom_range(7)] ^= 1'b1;
      send_beat(secded_pkg::FUNC_DECODE, w, c);
    end else if (kind < 82) begin
      w[a] = ~w[a];
      w[b] = ~w[b];
      send_beat(secded_pkg::FUNC_DECODE, w, c);
    end else if (kind < 88) begin
      w[a] = ~w[a];
      c[$urandom_range(7)] ^= 1'b1;
      send_beat(secded_pkg::FUNC_DECODE, w, c);
    end else begin
      send_beat(secded_pkg::FUNC_DECODE, w, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [63:0] w;
    sb = new();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    rsp_hold_cycles = 0;
    rst_ni <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.func <= secded_pkg::FUNC_ENCODE;
    req_ch.data_word <= '0;
    req_ch.check_in <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes and every decode case
    send_idle_pct = 30;
    rsp_stall_pct = 30;
    w = {$urandom, $urandom};
    send_beat(secded_pkg::FUNC_ENCODE, 64'h0, 8'h00);
    send_beat(secded_pkg::FUNC_ENCODE, '1, 8'hFF);
    send_beat(secded_pkg::FUNC_ENCODE, 64'h1, 8'h00);
    send_beat(secded_pkg::FUNC_ENCODE, 64'h8000_0000_0000_0000, 8'h5A);
    send_decode(64'h0, 8'hFF, 8'h00);           // clean all-zero word
    send_decode('1, 8'hFF, 8'h00);              // clean all-ones word
    send_decode(w, 8'hFF, 8'h00);               // clean random word
    send_decode(w, 8'hFF, 8'h80);               // overall parity bit only
    send_decode(w, 8'd0, 8'h00);                // single data bit, lowest
    send_decode('1, 8'd63, 8'h00);              // single data bit, highest
    send_decode(w, 8'hFF, 8'h01);               // Hamming check bit 0
    send_decode(w, 8'hFF, 8'h40);               // Hamming check bit 6
    send_decode(w, 8'hFF, 8'h7F);               // odd syndrome 127
    send_decode(w, 8'hFF, 8'hC8);               // odd syndrome 72
    send_decode(w, 8'hFF, 8'h48);               // even, syndrome 72
    send_decode(w, 8'd5, 8'h80);                // data bit plus parity bit
    send_beat(secded_pkg::FUNC_DECODE, w ^ 64'h3, sb.check_byte(w)); // two data bits
    send_beat(secded_pkg::FUNC_DECODE, 64'h0, 8'hFF);       // check byte all ones
    send_beat(secded_pkg::FUNC_DECODE, '1, 8'h00);
    send_beat(secded_pkg::FUNC_ENCODE, w, 8'hFF);
    drain_results();

    // Random phases with different idling; long hold-offs fill the pipeline
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 64; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 64; end
        default: begin send_idle_pct = 7; rsp_stall_pct = 7; end
      endcase
      for (int n = 0; n < 250; n++) begin
        if ((ph == 0 || ph == 3) && n == 100) rsp_hold_cycles = 200;
        send_random_item();
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
